// ----- src/terminal_op_stream_parser_core_defines.svh -----
// Shared assertion macros
`ifndef TERMINAL_OP_STREAM_PARSER_CORE_DEFINES_SVH
`define TERMINAL_OP_STREAM_PARSER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TOSP_CHECK(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tosp check failed");
`define TOSP_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tosp sequence check failed");
`else
`define TOSP_CHECK(label, cond)
`define TOSP_CHECK_NEXT(label, ante, cons)
`endif
`endif

// ----- src/tosp_pkg.sv -----
`timescale 1ns / 1ps
package tosp_pkg;
  localparam logic [3:0] K_CLEAR = 4'd0, K_HOME = 4'd1, K_POS = 4'd2, K_ATTR = 4'd3,
    K_WRITE = 4'd4, K_NEWLINE = 4'd5, K_XWRITE = 4'd6, K_TEXT = 4'd7, K_STATUS = 4'd8;
  localparam logic [3:0] S_OK = 4'd0, S_TOO_LARGE = 4'd1, S_TOO_MANY = 4'd2,
    S_BAD_POS = 4'd3, S_BAD_ATTR = 4'd4, S_BAD_LEN = 4'd5, S_BAD_XLEN = 4'd6,
    S_SPLIT = 4'd7, S_TRUNC = 4'd8, S_UNKNOWN = 4'd9;
  localparam logic [1:0] OP_POS = 2'd0, OP_ATTR = 2'd1, OP_WRITE = 2'd2, OP_XWRITE = 2'd3;
  localparam logic [15:0] OPC_CLEAR = 16'h43, OPC_HOME = 16'h48, OPC_NEWLINE = 16'h4E,
    OPC_POS = 16'h50, OPC_ATTR = 16'h41, OPC_WRITE = 16'h57, OPC_XWRITE = 16'h58;
  localparam logic [1:0] CFG_MAX_UNITS = 2'd0, CFG_MAX_OPS = 2'd1;
  localparam logic [19:0] UNITS_SAT = 20'hFFFFF;
  localparam logic [19:0] MAX_UNITS_RST = 20'd262144;
  localparam logic [15:0] MAX_OPS_RST = 16'd20000;
  localparam logic [15:0] REPL_CHAR = 16'hFFFD;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [3:0]  foreground;
    logic [3:0]  background;
    logic [15:0] text_bytes;
    logic [15:0] text_unit;
    logic [3:0]  status;
  } res_t;

  typedef struct packed {
    logic       two;
    res_t       r0;
    res_t       r1;
  } bundle_t;

  // bit 4: valid digit, [3:0]: value
  function automatic logic [4:0] hex_val(input logic [15:0] u);
    logic [4:0] v;
    v = 5'd0;
    if (u >= 16'h30 && u <= 16'h39) v = {1'b1, u[3:0]};
    else if ((u >= 16'h61 && u <= 16'h66) || (u >= 16'h41 && u <= 16'h46))
      v = {1'b1, u[3:0] + 4'd9};
    return v;
  endfunction

  function automatic logic [3:0] hex_err(input logic [1:0] op);
    logic [3:0] e;
    unique case (op)
      OP_POS:   e = S_BAD_POS;
      OP_ATTR:  e = S_BAD_ATTR;
      OP_WRITE: e = S_BAD_LEN;
      default:  e = S_BAD_XLEN;
    endcase
    return e;
  endfunction

  function automatic res_t mk_text(input logic [15:0] u);
    res_t r;
    r = '0;
    r.kind = K_TEXT;
    r.text_unit = u;
    return r;
  endfunction
endpackage

// ----- src/tosp_in_if.sv -----
`timescale 1ns / 1ps
interface tosp_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] code_unit;
  modport source (output valid, mode, code_unit, input ready);
  modport sink (input valid, mode, code_unit, output ready);
endinterface

// ----- src/tosp_out_if.sv -----
`timescale 1ns / 1ps
interface tosp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [7:0]  row;
  logic [7:0]  column;
  logic [3:0]  foreground;
  logic [3:0]  background;
  logic [15:0] text_bytes;
  logic [15:0] text_unit;
  logic [3:0]  status;
  logic        last;
  modport source (output valid, kind, row, column, foreground, background, text_bytes,
    text_unit, status, last, input ready);
  modport sink (input valid, kind, row, column, foreground, background, text_bytes,
    text_unit, status, last, output ready);
endinterface

// ----- src/tosp_cfg_if.sv -----
`timescale 1ns / 1ps
interface tosp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/terminal_op_stream_parser_core.sv -----
`timescale 1ns / 1ps
// Terminal op stream parser. One code unit (or frame end) is taken per cycle;
// each transaction yields zero, one or two results, and the output side sends
// one result per cycle while result.ready is high, from a two-entry queue;
// two results go out in turn. Input stalls only when that queue is full.
module terminal_op_stream_parser_core (
  input  logic        clk,
  input  logic        rst,
  tosp_in_if.sink     feed,
  tosp_cfg_if.sink    cfg,
  tosp_out_if.source  result
);
  import tosp_pkg::*;

  logic    push, pop, full, empty;
  bundle_t push_data, head;

  tosp_front u_front (.clk, .rst, .feed, .cfg, .q_full(full), .push, .push_data);
  tosp_fifo u_fifo (.clk, .rst, .push, .push_data, .pop, .full, .empty, .head);
  tosp_back u_back (.clk, .rst, .empty, .head, .pop, .result);
endmodule

// ----- src/tosp_front.sv -----
`timescale 1ns / 1ps
module tosp_front (
  input  logic              clk,
  input  logic              rst,
  tosp_in_if.sink           feed,
  tosp_cfg_if.sink          cfg,
  input  logic              q_full,
  output logic              push,
  output tosp_pkg::bundle_t push_data
);
  import tosp_pkg::*;

  localparam logic [1:0] PH_OPCODE = 2'd0, PH_HEX = 2'd1, PH_TEXT = 2'd2;

  logic [19:0] max_units;
  logic [15:0] max_ops;
  logic [1:0]  phase, phase_next;
  logic [1:0]  cur_op, cur_op_next;
  logic [15:0] acc, acc_next;
  logic [2:0]  digits, digits_next;
  logic [15:0] target, target_next;
  logic [16:0] tcount, tcount_next;
  logic        held, held_next;
  logic [15:0] held_unit, held_unit_next;
  logic [15:0] ops, ops_next;
  logic [19:0] units, units_next;
  logic [3:0]  err, err_next;
  logic [1:0]  n;
  res_t        r0, r1, rr;
  logic        go;
  logic        is_high, is_low;
  logic [4:0]  hv;
  logic [1:0]  nbytes;
  logic [15:0] u;
  logic        accept;

  assign feed.ready = !q_full;
  assign cfg.ready  = 1'b1;
  assign accept = feed.valid && feed.ready;
  assign u = feed.code_unit;
  assign is_high = u >= 16'hD800 && u <= 16'hDBFF;
  assign is_low  = u >= 16'hDC00 && u <= 16'hDFFF;
  assign hv = hex_val(u);
  assign nbytes = (u < 16'h80) ? 2'd1 : ((u < 16'h800) ? 2'd2 : 2'd3);

  always_comb begin
    phase_next = phase; cur_op_next = cur_op; acc_next = acc; digits_next = digits;
    target_next = target; tcount_next = tcount; held_next = held;
    held_unit_next = held_unit; ops_next = ops; units_next = units; err_next = err;
    n = 2'd0; r0 = '0; r1 = '0; rr = '0; go = 1'b1;
    if (feed.mode) begin
      if (err == S_OK) begin
        if (phase == PH_HEX) begin
          err_next = hex_err(cur_op);
        end else if (phase == PH_TEXT) begin
          if (held) begin
            if ({1'b0, tcount} + 18'd3 > {2'b00, target}) begin
              err_next = S_SPLIT; go = 1'b0;
            end else begin
              r0 = mk_text(REPL_CHAR); n = 2'd1;
              tcount_next = tcount + 17'd3;
            end
          end
          if (go && tcount_next != {1'b0, target}) err_next = S_TRUNC;
        end
      end
      rr.kind = K_STATUS;
      rr.status = (units > max_units) ? S_TOO_LARGE : err_next;
      if (n == 2'd0) r0 = rr; else r1 = rr;
      n = n + 2'd1;
      phase_next = PH_OPCODE; cur_op_next = '0; acc_next = '0; digits_next = '0;
      target_next = '0; tcount_next = '0; held_next = 1'b0; held_unit_next = '0;
      ops_next = '0; units_next = '0; err_next = S_OK;
    end else begin
      if (units == UNITS_SAT) begin
        err_next = S_TOO_LARGE;
      end else begin
        units_next = units + 20'd1;
        if (units_next > max_units) err_next = S_TOO_LARGE;
      end
      if (err_next == S_OK) begin
        if (phase == PH_TEXT && held) begin
          held_next = 1'b0;
          if (is_low) begin
            go = 1'b0;
            if ({1'b0, tcount} + 18'd4 > {2'b00, target}) begin
              err_next = S_SPLIT;
            end else begin
              r0 = mk_text(held_unit); r1 = mk_text(u); n = 2'd2;
              tcount_next = tcount + 17'd4;
              if (tcount_next == {1'b0, target}) phase_next = PH_OPCODE;
            end
          end else if ({1'b0, tcount} + 18'd3 > {2'b00, target}) begin
            err_next = S_SPLIT; go = 1'b0;
          end else begin
            r0 = mk_text(REPL_CHAR); n = 2'd1;
            tcount_next = tcount + 17'd3;
            if (tcount_next == {1'b0, target}) phase_next = PH_OPCODE;
          end
        end
        if (go) begin
          rr = '0;
          unique case (phase_next)
            PH_OPCODE: begin
              if (ops >= max_ops) begin
                err_next = S_TOO_MANY;
              end else begin
                ops_next = ops + 16'd1;
                unique case (u) inside
                  OPC_CLEAR:   begin rr.kind = K_CLEAR;   go = 1'b1; end
                  OPC_HOME:    begin rr.kind = K_HOME;    go = 1'b1; end
                  OPC_NEWLINE: begin rr.kind = K_NEWLINE; go = 1'b1; end
                  OPC_POS, OPC_ATTR, OPC_WRITE, OPC_XWRITE: begin
                    go = 1'b0;
                    phase_next = PH_HEX; acc_next = '0; digits_next = '0;
                    cur_op_next = (u == OPC_POS) ? OP_POS : (u == OPC_ATTR) ? OP_ATTR :
                                  (u == OPC_WRITE) ? OP_WRITE : OP_XWRITE;
                  end
                  default: begin err_next = S_UNKNOWN; go = 1'b0; end
                endcase
                if (go) begin
                  if (n == 2'd0) r0 = rr; else r1 = rr;
                  n = n + 2'd1;
                end
              end
            end
            PH_HEX: begin
              if (!hv[4]) begin
                err_next = hex_err(cur_op);
              end else begin
                acc_next = {acc[11:0], hv[3:0]};
                digits_next = digits + 3'd1;
                if (digits_next >= ((cur_op == OP_ATTR || cur_op == OP_WRITE) ? 3'd2 : 3'd4))
                begin
                  phase_next = PH_OPCODE;
                  if (cur_op == OP_POS) begin
                    rr.kind = K_POS; rr.row = acc_next[15:8]; rr.column = acc_next[7:0];
                  end else if (cur_op == OP_ATTR) begin
                    rr.kind = K_ATTR; rr.foreground = acc_next[7:4];
                    rr.background = acc_next[3:0];
                  end else begin
                    rr.kind = (cur_op == OP_WRITE) ? K_WRITE : K_XWRITE;
                    rr.text_bytes = acc_next;
                    if (acc_next != 16'd0) begin
                      phase_next = PH_TEXT; target_next = acc_next;
                      tcount_next = '0; held_next = 1'b0;
                    end
                  end
                  r0 = rr; n = 2'd1;
                end
              end
            end
            default: begin
              if (is_high) begin
                held_next = 1'b1; held_unit_next = u;
              end else if ({1'b0, tcount_next} + {16'd0, nbytes} > {2'b00, target}) begin
                err_next = S_SPLIT; held_next = 1'b0;
              end else begin
                rr = mk_text(is_low ? REPL_CHAR : u);
                if (n == 2'd0) r0 = rr; else r1 = rr;
                n = n + 2'd1;
                tcount_next = tcount_next + {15'd0, nbytes};
                if (tcount_next == {1'b0, target}) phase_next = PH_OPCODE;
              end
            end
          endcase
        end
      end
    end
  end

  assign push = accept && (n != 2'd0);
  assign push_data = '{two: n == 2'd2, r0: r0, r1: r1};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_units <= MAX_UNITS_RST; max_ops <= MAX_OPS_RST;
      phase <= PH_OPCODE; cur_op <= '0; acc <= '0; digits <= '0; target <= '0;
      tcount <= '0; held <= 1'b0; held_unit <= '0; ops <= '0; units <= '0; err <= S_OK;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_MAX_UNITS: max_units <= cfg.data;
          CFG_MAX_OPS:   max_ops <= cfg.data[15:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase <= phase_next; cur_op <= cur_op_next; acc <= acc_next;
        digits <= digits_next; target <= target_next; tcount <= tcount_next;
        held <= held_next; held_unit <= held_unit_next; ops <= ops_next;
        units <= units_next; err <= err_next;
      end
    end
  end
endmodule

// ----- src/tosp_fifo.sv -----
`timescale 1ns / 1ps
`include "terminal_op_stream_parser_core_defines.svh"
module tosp_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tosp_pkg::bundle_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output tosp_pkg::bundle_t head
);
  import tosp_pkg::*;

  bundle_t     mem [2];
  logic        wptr, rptr;
  logic [1:0]  count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0; rptr <= 1'b0; count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `TOSP_CHECK(a_count_range, count <= 2'd2)
  `TOSP_CHECK(a_no_overflow, !(push && full))
  `TOSP_CHECK(a_no_underflow, !(pop && empty))
  `TOSP_CHECK_NEXT(a_push_fills, push && !pop, !empty)
endmodule

// ----- src/tosp_back.sv -----
`timescale 1ns / 1ps
module tosp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  tosp_pkg::bundle_t head,
  output logic              pop,
  tosp_out_if.source        result
);
  import tosp_pkg::*;

  logic idx;
  logic fin;
  res_t cur;

  assign cur = idx ? head.r1 : head.r0;
  assign fin = idx || !head.two;
  assign result.valid      = !empty;
  assign result.kind       = cur.kind;
  assign result.row        = cur.row;
  assign result.column     = cur.column;
  assign result.foreground = cur.foreground;
  assign result.background = cur.background;
  assign result.text_bytes = cur.text_bytes;
  assign result.text_unit  = cur.text_unit;
  assign result.status     = cur.status;
  assign result.last       = fin;
  assign pop = result.valid && result.ready && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 1'b0;
    end else if (result.valid && result.ready) begin
      idx <= !fin;
    end
  end
endmodule
